[rtl/rpnse_pkg.sv]
// Shared types and constants for the RPN stack evaluator.
`default_nettype none

package rpnse_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DEPTH_W  = 4;

  localparam int unsigned DEF_STACK_DEPTH = 10;
  localparam int unsigned DEF_FRAC_BITS   = 16;

  // Operation codes; 6 and 7 are bad operators.
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB    = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
  localparam logic [OP_W-1:0] OP_FINISH = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADOP     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd5;

  localparam logic [DATA_W-1:0] DATA_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
  } rpnse_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
    logic                     done_res;
  } rpnse_rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic read;
    logic mul;
    logic div_start;
    logic commit;
  } rpnse_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_operand;
    logic is_mul;
    logic is_div;
    logic div_done;
    logic out_free;
  } rpnse_sts_t;

endpackage

`default_nettype wire

[rtl/rpn_stack_evaluator.sv]
// Each request passes decode and commit; an error-free mul adds a multiply state, and
// an error-free div adds a load state and the run of the restoring divider, which yields
// one quotient bit per cycle. One request is worked on at a time; the next is taken
// once the previous result sits in the output register, even if it is not yet taken.
// Reset clears the stack count, the error latch and the output valid; stack entries are
// left as they are and are never read before being written.
`default_nettype none

module rpn_stack_evaluator import rpnse_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned FRAC_BITS   = DEF_FRAC_BITS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire rpnse_req_t in_req_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output rpnse_rsp_t      out_rsp_o
);

  rpnse_cmd_t cmd;
  rpnse_sts_t sts;

  rpnse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpnse_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // An accepted request keeps the input side busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while previous one still in progress");

  // Never overwrite a result that is still waiting.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> sts.out_free)
    else $error("result committed over a pending output");

  // A committed result is visible on the next cycle.
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("committed result not presented");

  // Finish always leaves the stack empty.
  a_finish_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.done_res) |-> (out_rsp_o.depth == '0))
    else $error("finish result with nonzero depth");

endmodule

`default_nettype wire

[rtl/rpnse_div.sv]
// Radix-2 restoring divider for saturated fixed-point quotients.
`default_nettype none

module rpnse_div import rpnse_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic signed [DATA_W-1:0] dividend_i,
  input  wire logic signed [DATA_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [DATA_W-1:0]             result_o
);

  localparam int unsigned QW    = DATA_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic [QW-1:0]     q_q;
  logic [DATA_W-1:0] r_q;
  logic [DATA_W-1:0] d_q;
  logic              neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              run_q, fin_q, done_q;
  logic [DATA_W-1:0] result_q;

  logic [DATA_W-1:0] abs_a, abs_b;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W+1:0] diff;
  logic              fits;
  logic [DATA_W-1:0] sat_res;

  always_comb begin
    abs_a  = dividend_i[DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
    abs_b  = divisor_i[DATA_W-1] ? (~divisor_i + 1'b1) : divisor_i;
    rem_sh = {r_q, q_q[QW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, d_q};
    fits   = !diff[DATA_W+1];
  end

  always_comb begin
    if (!neg_q) begin
      sat_res = (q_q > QW'(64'h7fff_ffff)) ? DATA_MAX : q_q[DATA_W-1:0];
    end else begin
      sat_res = (q_q > QW'(64'h8000_0000)) ? DATA_MIN : (~q_q[DATA_W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(QW);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_q <= 1'b0;
        fin_q <= 1'b1;
      end
    end else if (fin_q) begin
      fin_q  <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= QW'(abs_a) << FRAC_BITS;
      r_q   <= '0;
      d_q   <= abs_b;
      neg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
    end else if (run_q) begin
      q_q <= {q_q[QW-2:0], fits};
      r_q <= fits ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
    end
    if (fin_q) begin
      result_q <= sat_res;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

[rtl/rpnse_ctrl.sv]
// Sequencing state machine for the RPN stack evaluator.
`default_nettype none

module rpnse_ctrl import rpnse_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire rpnse_sts_t sts_i,
  output rpnse_cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECODE   = 6'b000010,
    S_MUL      = 6'b000100,
    S_DIV_LOAD = 6'b001000,
    S_DIV_RUN  = 6'b010000,
    S_COMMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.need_operand) begin
          cmd_o.read = 1'b1;
          if (sts_i.is_mul) begin
            state_d = S_MUL;
          end else if (sts_i.is_div) begin
            state_d = S_DIV_LOAD;
          end else begin
            state_d = S_COMMIT;
          end
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_COMMIT;
      end
      S_DIV_LOAD: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (sts_i.div_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

[rtl/rpnse_dpath.sv]
// Stack storage, arithmetic and output register of the RPN stack evaluator.
`default_nettype none

module rpnse_dpath import rpnse_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned FRAC_BITS   = DEF_FRAC_BITS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire rpnse_req_t in_req_i,
  input  wire rpnse_cmd_t cmd_i,
  output rpnse_sts_t      sts_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output rpnse_rsp_t      out_rsp_o
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
  localparam int unsigned MUL_W = 2 * DATA_W;

  localparam logic signed [MUL_W-1:0] MUL_MAX = 64'sd2147483647;
  localparam logic signed [MUL_W-1:0] MUL_MIN = -64'sd2147483648;

  // Entries below the top; the top itself lives in top_q.
  logic [DATA_W-1:0] mem_q [STACK_DEPTH];

  logic [OP_W-1:0]          op_q;
  logic [DATA_W-1:0]        val_q;
  logic signed [DATA_W-1:0] top_q, top_d;
  logic signed [DATA_W-1:0] opnd_q;
  logic signed [MUL_W-1:0]  prod_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [STATUS_W-1:0]      err_q, err_d;
  logic                     out_valid_q;
  rpnse_rsp_t               out_rsp_q, rsp_d;

  logic [CNT_W-1:0]         cnt_m1, cnt_m2;
  logic [IDX_W-1:0]         rd_idx, wr_idx;
  logic                     mem_we;
  logic                     arith_op;
  logic signed [DATA_W:0]   sum_w, dif_w;
  logic signed [MUL_W-1:0]  mul_sh;
  logic [DATA_W-1:0]        add_res, sub_res, mul_res;
  logic                     div_done;
  logic [DATA_W-1:0]        div_res;

  assign cnt_m1 = count_q - 1'b1;
  assign cnt_m2 = count_q - CNT_W'(2);
  assign rd_idx = cnt_m2[IDX_W-1:0];
  assign wr_idx = cnt_m1[IDX_W-1:0];

  assign arith_op = (op_q == OP_ADD) || (op_q == OP_SUB) ||
                    (op_q == OP_MUL) || (op_q == OP_DIV);

  assign sts_o.need_operand = (err_q == ST_OK) && arith_op && (count_q >= CNT_W'(2)) &&
                              !((op_q == OP_DIV) && (top_q == '0));
  assign sts_o.is_mul   = (op_q == OP_MUL);
  assign sts_o.is_div   = (op_q == OP_DIV);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  rpnse_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (opnd_q),
    .divisor_i  (top_q),
    .done_o     (div_done),
    .result_o   (div_res)
  );

  // Saturating add, subtract and floor-shifted product.
  always_comb begin
    sum_w   = {opnd_q[DATA_W-1], opnd_q} + {top_q[DATA_W-1], top_q};
    dif_w   = {opnd_q[DATA_W-1], opnd_q} - {top_q[DATA_W-1], top_q};
    add_res = (sum_w[DATA_W] != sum_w[DATA_W-1]) ?
              (sum_w[DATA_W] ? DATA_MIN : DATA_MAX) : sum_w[DATA_W-1:0];
    sub_res = (dif_w[DATA_W] != dif_w[DATA_W-1]) ?
              (dif_w[DATA_W] ? DATA_MIN : DATA_MAX) : dif_w[DATA_W-1:0];
    mul_sh  = prod_q >>> FRAC_BITS;
    if (mul_sh > MUL_MAX) begin
      mul_res = DATA_MAX;
    end else if (mul_sh < MUL_MIN) begin
      mul_res = DATA_MIN;
    end else begin
      mul_res = mul_sh[DATA_W-1:0];
    end
  end

  // Next stack state and result of the held request.
  always_comb begin
    count_d        = count_q;
    top_d          = top_q;
    err_d          = err_q;
    mem_we         = 1'b0;
    rsp_d          = '0;
    rsp_d.status   = ST_OK;
    if (op_q == OP_FINISH) begin
      if (err_q != ST_OK) begin
        rsp_d.status = err_q;
      end else if (count_q != CNT_W'(1)) begin
        rsp_d.status = ST_MALFORMED;
      end else begin
        rsp_d.top_value = top_q;
      end
      count_d        = '0;
      err_d          = ST_OK;
      rsp_d.done_res = 1'b1;
    end else begin
      if (err_q != ST_OK) begin
        rsp_d.status = err_q;
      end else if (op_q == OP_PUSH) begin
        if (count_q == CNT_W'(STACK_DEPTH)) begin
          rsp_d.status = ST_OVERFLOW;
        end else begin
          mem_we  = (count_q != '0);
          top_d   = val_q;
          count_d = count_q + 1'b1;
        end
      end else if (count_q < CNT_W'(2)) begin
        err_d        = ST_UNDERFLOW;
        rsp_d.status = ST_UNDERFLOW;
      end else begin
        case (op_q)
          OP_ADD: begin
            top_d   = add_res;
            count_d = cnt_m1;
          end
          OP_SUB: begin
            top_d   = sub_res;
            count_d = cnt_m1;
          end
          OP_MUL: begin
            top_d   = mul_res;
            count_d = cnt_m1;
          end
          OP_DIV: begin
            if (top_q == '0) begin
              err_d        = ST_DIVZERO;
              rsp_d.status = ST_DIVZERO;
            end else begin
              top_d   = div_res;
              count_d = cnt_m1;
            end
          end
          default: begin
            err_d        = ST_BADOP;
            rsp_d.status = ST_BADOP;
          end
        endcase
      end
      rsp_d.top_value = (count_d == '0) ? '0 : top_d;
    end
    rsp_d.depth = DEPTH_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        count_q     <= count_d;
        err_q       <= err_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_req_i.op;
      val_q <= in_req_i.value;
    end
    if (cmd_i.mul) begin
      prod_q <= opnd_q * top_q;
    end
    if (cmd_i.commit) begin
      top_q     <= top_d;
      out_rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && mem_we) begin
      mem_q[wr_idx] <= top_q;
    end
    if (cmd_i.read) begin
      opnd_q <= mem_q[rd_idx];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the RPN stack evaluator: directed corners plus random traffic.
`default_nettype none

module testbench;
  import rpnse_pkg::*;

  localparam int unsigned STACK_DEPTH = DEF_STACK_DEPTH;
  localparam int unsigned FRAC_BITS   = DEF_FRAC_BITS;

  // Op codes past finish are bad operators.
  localparam logic [OP_W-1:0] OP_BAD_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] FX_ONE       = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] FX_MINUS_ONE = 32'shffff_0000;
  localparam logic signed [DATA_W-1:0] FX_LSB_NEG   = 32'shffff_ffff;

  localparam int unsigned DRAIN_CYCLES = DATA_W + FRAC_BITS + 20;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  rpnse_req_t in_req_i;
  logic       out_valid_o;
  logic       out_stall_i;
  rpnse_rsp_t out_rsp_o;

  rpn_stack_evaluator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Evaluator state mirrored by the predictor.
  logic signed [DATA_W-1:0] operand_stack [STACK_DEPTH];
  int unsigned              operand_count;
  logic [STATUS_W-1:0]      sticky_error;

  rpnse_rsp_t  pending_results [$];
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned finishes_seen;
  int unsigned error_results;
  int unsigned mismatch_count;
  int unsigned sender_idle_pct;
  int unsigned recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] clamp_word(input longint v);
    if (v > 64'sd2147483647) return DATA_MAX;
    if (v < -64'sd2147483648) return DATA_MIN;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] top_of_stack();
    if (operand_count == 0) return '0;
    return operand_stack[operand_count-1];
  endfunction

  // Advance the mirrored stack by one request and return the result it must produce.
  function automatic rpnse_rsp_t evaluate_request(input rpnse_req_t req);
    rpnse_rsp_t rsp;
    longint     lhs;
    longint     rhs;
    longint     res;
    logic       ok;
    rsp = '0;
    rsp.status = ST_OK;
    if (req.op == OP_FINISH) begin
      if (sticky_error != ST_OK) begin
        rsp.status = sticky_error;
      end else if (operand_count != 1) begin
        rsp.status = ST_MALFORMED;
      end else begin
        rsp.top_value = operand_stack[0];
      end
      operand_count = 0;
      sticky_error = ST_OK;
      rsp.done_res = 1'b1;
    end else begin
      if (sticky_error != ST_OK) begin
        rsp.status = sticky_error;
      end else if (req.op == OP_PUSH) begin
        if (operand_count >= STACK_DEPTH) begin
          rsp.status = ST_OVERFLOW;
        end else begin
          operand_stack[operand_count] = req.value;
          operand_count++;
        end
      end else if (operand_count < 2) begin
        sticky_error = ST_UNDERFLOW;
        rsp.status = ST_UNDERFLOW;
      end else begin
        lhs = operand_stack[operand_count-2];
        rhs = operand_stack[operand_count-1];
        res = 0;
        ok = 1'b1;
        case (req.op)
          OP_ADD: res = lhs + rhs;
          OP_SUB: res = lhs - rhs;
          OP_MUL: res = (lhs * rhs) >>> FRAC_BITS;
          OP_DIV: begin
            if (rhs == 0) begin
              sticky_error = ST_DIVZERO;
              ok = 1'b0;
            end else begin
              res = (lhs * (longint'(1) << FRAC_BITS)) / rhs;
            end
          end
          default: begin
            sticky_error = ST_BADOP;
            ok = 1'b0;
          end
        endcase
        if (ok) begin
          operand_count--;
          operand_stack[operand_count-1] = clamp_word(res);
        end else begin
          rsp.status = sticky_error;
        end
      end
      rsp.top_value = top_of_stack();
    end
    rsp.depth = DEPTH_W'(operand_count);
    return rsp;
  endfunction

  // Entered and left at a falling edge; valid stays high between back-to-back requests.
  task automatic send_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
    rpnse_req_t req;
    req.op = op;
    req.value = value;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      in_req_i <= rpnse_req_t'({$urandom(), $urandom()});
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(evaluate_request(req));
    requests_sent++;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (recv_stall_pct == 0) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    rpnse_rsp_t exp_rsp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d top_value %0d depth %0d done_res %0b",
               out_rsp_o.status, out_rsp_o.top_value, out_rsp_o.depth, out_rsp_o.done_res);
        mismatch_count++;
      end else begin
        exp_rsp = pending_results.pop_front();
        results_checked++;
        if (exp_rsp.done_res) finishes_seen++;
        if (exp_rsp.status != ST_OK) error_results++;
        if (out_rsp_o.status !== exp_rsp.status) begin
          $error("status: expected %0d, actual %0d", exp_rsp.status, out_rsp_o.status);
          mismatch_count++;
        end
        if (out_rsp_o.top_value !== exp_rsp.top_value) begin
          $error("top_value: expected %0d, actual %0d", exp_rsp.top_value, out_rsp_o.top_value);
          mismatch_count++;
        end
        if (out_rsp_o.depth !== exp_rsp.depth) begin
          $error("depth: expected %0d, actual %0d", exp_rsp.depth, out_rsp_o.depth);
          mismatch_count++;
        end
        if (out_rsp_o.done_res !== exp_rsp.done_res) begin
          $error("done_res: expected %0b, actual %0b", exp_rsp.done_res, out_rsp_o.done_res);
          mismatch_count++;
        end
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_operand();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(9))
      0: v = DATA_MAX;
      1: v = DATA_MIN;
      2: v = '0;
      3: v = DATA_W'($urandom_range(20)) << FRAC_BITS;
      4, 5: v = DATA_W'($urandom_range(32'h0004_0000));
      default: v = $urandom();
    endcase
    if ($urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  function automatic logic [OP_W-1:0] pick_arith_op();
    case ($urandom_range(3))
      0: return OP_ADD;
      1: return OP_SUB;
      2: return OP_MUL;
      default: return OP_DIV;
    endcase
  endfunction

  // Well-formed postfix expression, then finish.
  task automatic send_expression();
    int unsigned leaves;
    int unsigned pushed;
    int unsigned live;
    leaves = ($urandom_range(9) == 0) ? $urandom_range(7, STACK_DEPTH) : $urandom_range(1, 5);
    pushed = 0;
    live = 0;
    while (pushed < leaves || live > 1) begin
      if (live >= 2 && (pushed == leaves || $urandom_range(1) == 1)) begin
        send_request(pick_arith_op(), $urandom());
        live--;
      end else begin
        send_request(OP_PUSH, pick_operand());
        pushed++;
        live++;
      end
    end
    send_request(OP_FINISH, $urandom());
  endtask

  // Fill near or past the top of the stack, fold a little, then finish.
  task automatic send_deep_fill();
    int unsigned n;
    n = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 2);
    repeat (n) send_request(OP_PUSH, pick_operand());
    repeat ($urandom_range(3)) send_request(pick_arith_op(), $urandom());
    send_request(OP_FINISH, $urandom());
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) send_request(OP_W'($urandom_range(7)), $urandom());
    send_request(OP_FINISH, $urandom());
  endtask

  task automatic test_saturation();
    send_request(OP_FINISH, '0);
    send_request(OP_PUSH, DATA_MAX);
    send_request(OP_PUSH, FX_ONE);
    send_request(OP_ADD, '0);
    send_request(OP_PUSH, DATA_MIN);
    send_request(OP_MUL, '0);
    send_request(OP_PUSH, FX_LSB_NEG);
    send_request(OP_SUB, '1);
    send_request(OP_FINISH, '1);
  endtask

  task automatic test_divide();
    send_request(OP_PUSH, DATA_MIN);
    send_request(OP_PUSH, FX_MINUS_ONE);
    send_request(OP_DIV, '0);
    send_request(OP_PUSH, '0);
    send_request(OP_DIV, '0);
    send_request(OP_PUSH, FX_ONE);
    send_request(OP_FINISH, '0);
  endtask

  task automatic test_error_latching();
    // A bad operator on a short stack reports underflow.
    send_request(OP_BAD_HI, '0);
    send_request(OP_FINISH, '0);
    send_request(OP_PUSH, FX_ONE);
    send_request(OP_PUSH, FX_MINUS_ONE);
    send_request(OP_BAD_LO, '0);
    send_request(OP_FINISH, '0);
  endtask

  task automatic test_stack_overflow();
    for (int i = 0; i < STACK_DEPTH + 1; i++) begin
      send_request(OP_PUSH, (i % 2 == 0) ? DATA_MAX : DATA_MIN);
    end
    send_request(OP_SUB, '0);
    send_request(OP_FINISH, '0);
  endtask

  task automatic test_random_traffic(input int unsigned n_requests,
                                     input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned target;
    int unsigned pick;
    sender_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = requests_sent + n_requests;
    while (requests_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_expression();
      end else if (pick < 80) begin
        send_deep_fill();
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    operand_count = 0;
    sticky_error = ST_OK;
    requests_sent = 0;
    results_checked = 0;
    finishes_seen = 0;
    error_results = 0;
    mismatch_count = 0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_saturation();
    test_divide();
    test_error_latching();
    test_stack_overflow();
    test_random_traffic(290, 0, 0);
    test_random_traffic(290, 88, 0);
    test_random_traffic(290, 0, 88);
    test_random_traffic(290, 26, 26);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests across four traffic mixes; %0d results checked.",
             requests_sent, results_checked);
    $display("Expressions finished: %0d; results carrying an error status: %0d.",
             finishes_seen, error_results);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
